@@ rtl/tetra_barycentric_coords_core_assert.svh @@
// ---------------------------------------------------------------------------
// tetra barycentric coords core assertion macros
// immediate-consequence and next-cycle checks, clocked on clock, off in reset
// ---------------------------------------------------------------------------
`ifndef TETRA_BARYCENTRIC_COORDS_CORE_ASSERT_SVH
`define TETRA_BARYCENTRIC_COORDS_CORE_ASSERT_SVH

// consequence must hold in the same cycle
`define TBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the following cycle
`define TBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tbc_pkg.sv @@
// ---------------------------------------------------------------------------
// tbc_pkg
// shared constants for the tetrahedron barycentric coordinate core
// ---------------------------------------------------------------------------
package tbc_pkg;

   localparam int FIELD_W          = 63;
   localparam int OUT_W            = 32;
   localparam int THR_W            = 63;
   localparam int CSR_DATA_W       = 64;
   localparam int CSR_ADDR_W       = 3;
   localparam int THRESH_FRAC_BITS = 30;
   // quotient bits kept: twice the rounded result plus headroom for saturation
   localparam int QUO_W            = 34;
   localparam int FRONT_STAGES     = 7;

   localparam int DEF_COORD_BITS      = 21;
   localparam int DEF_COORD_FRAC_BITS = 10;
   localparam int DEF_OUT_FRAC_BITS   = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_DET_THRESHOLD = 3'd0;
   localparam logic [THR_W-1:0]      THR_RESET         = 63'd1;

   localparam logic [QUO_W-1:0] LIM_POS = QUO_W'(64'h7FFF_FFFF);
   localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(64'h8000_0000);

endpackage

@@ rtl/tetra_barycentric_coords_core.sv @@
// ---------------------------------------------------------------------------
// tetra_barycentric_coords_core
// local coordinates of a point in a tetrahedron by cramer's rule, pipelined
// ---------------------------------------------------------------------------
// Takes one transaction per cycle (a query point and vertices p, q, r, s)
// while the result side does not stall, and returns one result transaction
// per input, in order. The pipeline has 7 front stages (differences,
// cofactor products, cofactors, determinant and numerator products, sums,
// magnitudes, threshold compare), then 34 restoring-division stages, one
// quotient bit each for all three coordinates, then one rounding and
// saturation stage that is also the output register. Stall is handled per
// stage: a stage loads when it is empty or when the stage after it moves,
// so bubbles close up while the output waits. The degenerate threshold sits
// in one 63-bit register at csr address 0; it is read at the threshold
// compare in stage 7, so a write also reaches transactions still in the
// first stages; write it only while the pipeline is empty.
`include "tetra_barycentric_coords_core_assert.svh"

module tetra_barycentric_coords_core
   import tbc_pkg::*;
#(
   parameter int COORD_BITS      = DEF_COORD_BITS,
   parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
   parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // input transactions
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FIELD_W-1:0]    req_point_xyz,
   input  logic [FIELD_W-1:0]    req_vertex_p,
   input  logic [FIELD_W-1:0]    req_vertex_q,
   input  logic [FIELD_W-1:0]    req_vertex_r,
   input  logic [FIELD_W-1:0]    req_vertex_s,
   // result transactions
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [OUT_W-1:0] rsp_coord_a,
   output logic signed [OUT_W-1:0] rsp_coord_b,
   output logic signed [OUT_W-1:0] rsp_coord_c,
   output logic                  rsp_degenerate,
   output logic                  rsp_saturated,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // derived widths
   localparam int CB   = COORD_BITS;
   localparam int DW   = CB + 1;            // coordinate difference
   localparam int PW   = 2 * DW;            // cofactor partial product
   localparam int CFW  = PW + 1;            // cofactor
   localparam int XW   = CFW + DW;          // determinant / numerator term
   localparam int DETW = XW + 2;            // determinant / numerator sum
   localparam int MW   = DETW;              // magnitudes
   localparam int RW   = MW + QUO_W + OUT_FRAC_BITS + 1;  // division remainder
   localparam int TW_A = MW + THRESH_FRAC_BITS;
   localparam int TW_B = THR_W + 3 * COORD_FRAC_BITS;
   localparam int TW   = ((TW_A > TW_B) ? TW_A : TW_B) + 1;
   localparam int NST  = FRONT_STAGES + QUO_W + 1;
   localparam logic [OUT_W-1:0] DEGEN_CODE = OUT_W'(0) - OUT_W'(64'd10 << OUT_FRAC_BITS);

   typedef struct packed {
      logic [2:0][RW-1:0]    rem;
      logic [2:0][QUO_W-1:0] quo;
      logic [2:0]            ovf;
      logic [2:0]            neg;
      logic [MW-1:0]         dmag;
      logic                  degen;
   } div_type;

   // ------------------------------------------------------------------
   // threshold register
   // ------------------------------------------------------------------
   logic [THR_W-1:0] thr_ff;
   logic             thr_wr;

   assign thr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_DET_THRESHOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (thr_wr) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_DET_THRESHOLD) ? CSR_DATA_W'(thr_ff) : '0;

   // ------------------------------------------------------------------
   // per-stage valid bits and ready chain
   // ------------------------------------------------------------------
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST-1:0] rdy;

   assign vld_src = {vld_ff[NST-2:0], req_valid};

   // a stage may load when empty or when the stage after it moves
   always_comb begin
      rdy[NST-1] = !vld_ff[NST-1] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NST-1];

   // ------------------------------------------------------------------
   // stage 1: edge vectors and point offset relative to p
   // ------------------------------------------------------------------
   logic [2:0][FIELD_W-1:0] vert;
   logic signed [DW-1:0] s1_m_in [3];
   logic signed [DW-1:0] s1_a_in [3][3];
   logic signed [DW-1:0] s1_m_ff [3];
   logic signed [DW-1:0] s1_a_ff [3][3];

   // column j of the edge matrix is vertex q, r or s minus p
   assign vert = {req_vertex_s, req_vertex_r, req_vertex_q};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_m_in[i] = DW'($signed(req_point_xyz[i*CB +: CB]))
                    - DW'($signed(req_vertex_p[i*CB +: CB]));
         for (int j = 0; j < 3; j++) begin
            s1_a_in[i][j] = DW'($signed(vert[j][i*CB +: CB]))
                          - DW'($signed(req_vertex_p[i*CB +: CB]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_m_ff <= s1_m_in;
         s1_a_ff <= s1_a_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: 2x2 minor products
   // ------------------------------------------------------------------
   logic signed [PW-1:0] s2_pp1_in [3][3];
   logic signed [PW-1:0] s2_pp2_in [3][3];
   logic signed [PW-1:0] s2_pp1_ff [3][3];
   logic signed [PW-1:0] s2_pp2_ff [3][3];
   logic signed [DW-1:0] s2_a0_ff [3];
   logic signed [DW-1:0] s2_m_ff [3];

   always_comb begin
      int i1, i2, j1, j2;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            j1 = (j == 2) ? 0 : j + 1;
            j2 = (j == 0) ? 2 : j - 1;
            s2_pp1_in[i][j] = PW'(s1_a_ff[i1][j1]) * PW'(s1_a_ff[i2][j2]);
            s2_pp2_in[i][j] = PW'(s1_a_ff[i1][j2]) * PW'(s1_a_ff[i2][j1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_pp1_ff <= s2_pp1_in;
         s2_pp2_ff <= s2_pp2_in;
         s2_a0_ff  <= s1_a_ff[0];
         s2_m_ff   <= s1_m_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: cofactors
   // ------------------------------------------------------------------
   logic signed [CFW-1:0] s3_c_in [3][3];
   logic signed [CFW-1:0] s3_c_ff [3][3];
   logic signed [DW-1:0]  s3_a0_ff [3];
   logic signed [DW-1:0]  s3_m_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s3_c_in[i][j] = CFW'(s2_pp1_ff[i][j]) - CFW'(s2_pp2_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_c_ff  <= s3_c_in;
         s3_a0_ff <= s2_a0_ff;
         s3_m_ff  <= s2_m_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: determinant terms (row 0 expansion) and numerator terms
   // ------------------------------------------------------------------
   logic signed [XW-1:0] s4_dp_in [3];
   logic signed [XW-1:0] s4_np_in [3][3];
   logic signed [XW-1:0] s4_dp_ff [3];
   logic signed [XW-1:0] s4_np_ff [3][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s4_dp_in[j] = XW'(s3_a0_ff[j]) * XW'(s3_c_ff[0][j]);
         // coordinate j uses column j of the cofactors against the offset
         for (int i = 0; i < 3; i++) begin
            s4_np_in[j][i] = XW'(s3_c_ff[i][j]) * XW'(s3_m_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_dp_ff <= s4_dp_in;
         s4_np_ff <= s4_np_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: determinant and numerator sums
   // ------------------------------------------------------------------
   logic signed [DETW-1:0] s5_det_in;
   logic signed [DETW-1:0] s5_num_in [3];
   logic signed [DETW-1:0] s5_det_ff;
   logic signed [DETW-1:0] s5_num_ff [3];

   always_comb begin
      s5_det_in = DETW'(s4_dp_ff[0]) + DETW'(s4_dp_ff[1]) + DETW'(s4_dp_ff[2]);
      for (int j = 0; j < 3; j++) begin
         s5_num_in[j] = DETW'(s4_np_ff[j][0]) + DETW'(s4_np_ff[j][1])
                      + DETW'(s4_np_ff[j][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s5_det_ff <= s5_det_in;
         s5_num_ff <= s5_num_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: signs and magnitudes
   // ------------------------------------------------------------------
   logic [2:0]    s6_neg_in;
   logic [MW-1:0] s6_nmag_in [3];
   logic [MW-1:0] s6_dmag_in;
   logic [2:0]    s6_neg_ff;
   logic [MW-1:0] s6_nmag_ff [3];
   logic [MW-1:0] s6_dmag_ff;
   logic          s6_dzero_ff;

   always_comb begin
      s6_dmag_in = s5_det_ff[DETW-1] ? $unsigned(DETW'(0) - s5_det_ff)
                                     : $unsigned(s5_det_ff);
      for (int j = 0; j < 3; j++) begin
         s6_neg_in[j]  = s5_num_ff[j][DETW-1] ^ s5_det_ff[DETW-1];
         s6_nmag_in[j] = s5_num_ff[j][DETW-1] ? $unsigned(DETW'(0) - s5_num_ff[j])
                                              : $unsigned(s5_num_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s6_neg_ff   <= s6_neg_in;
         s6_nmag_ff  <= s6_nmag_in;
         s6_dmag_ff  <= s6_dmag_in;
         s6_dzero_ff <= (s5_det_ff == '0);
      end
   end

   // ------------------------------------------------------------------
   // stage 7: threshold compare, division setup and overflow precheck
   // ------------------------------------------------------------------
   div_type div_in [QUO_W+1];
   div_type div_ff [QUO_W+1];
   logic [TW-1:0] thr_lhs;
   logic [TW-1:0] thr_rhs;
   logic [RW-1:0] dlim;

   // |det| and the threshold carry different fraction counts; align both
   assign thr_lhs = TW'(s6_dmag_ff) << THRESH_FRAC_BITS;
   assign thr_rhs = TW'(thr_ff) << (3 * COORD_FRAC_BITS);
   // quotient of twice the scaled numerator must stay below 2^QUO_W
   assign dlim    = RW'(s6_dmag_ff) << QUO_W;

   always_comb begin
      div_in[0].dmag  = s6_dmag_ff;
      div_in[0].neg   = s6_neg_ff;
      div_in[0].degen = s6_dzero_ff || (thr_lhs < thr_rhs);
      for (int j = 0; j < 3; j++) begin
         div_in[0].rem[j] = RW'(s6_nmag_ff[j]) << (OUT_FRAC_BITS + 1);
         div_in[0].quo[j] = '0;
         div_in[0].ovf[j] = (div_in[0].rem[j] >= dlim);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[FRONT_STAGES-1]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // ------------------------------------------------------------------
   // restoring division, one quotient bit per stage, msb first
   // ------------------------------------------------------------------
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int SH = QUO_W - 1 - k;
      logic [RW-1:0] dsh;
      logic [RW:0]   dif [3];

      assign dsh = RW'(div_ff[k].dmag) << SH;

      always_comb begin
         div_in[k+1] = div_ff[k];
         for (int j = 0; j < 3; j++) begin
            dif[j] = {1'b0, div_ff[k].rem[j]} - {1'b0, dsh};
            if (!dif[j][RW]) begin
               div_in[k+1].rem[j]     = dif[j][RW-1:0];
               div_in[k+1].quo[j][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[FRONT_STAGES+k]) begin
            div_ff[k+1] <= div_in[k+1];
         end
      end
   end

   // ------------------------------------------------------------------
   // output stage: round half away from zero, saturate, sign
   // ------------------------------------------------------------------
   logic [OUT_W-1:0] out_val [3];
   logic [2:0]       out_sat;
   logic [QUO_W:0]   rinc [3];
   logic [QUO_W-1:0] rnd [3];
   logic [QUO_W-1:0] lim [3];
   logic [QUO_W-1:0] mag [3];

   logic [OUT_W-1:0] rsp_coord_a_ff, rsp_coord_b_ff, rsp_coord_c_ff;
   logic             rsp_degenerate_ff, rsp_saturated_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         // quotient holds twice the ratio, so (t + 1) / 2 rounds it
         rinc[j]    = {1'b0, div_ff[QUO_W].quo[j]} + (QUO_W+1)'(1);
         rnd[j]     = rinc[j][QUO_W:1];
         lim[j]     = div_ff[QUO_W].neg[j] ? LIM_NEG : LIM_POS;
         out_sat[j] = div_ff[QUO_W].ovf[j] || (rnd[j] > lim[j]);
         mag[j]     = out_sat[j] ? lim[j] : rnd[j];
         out_val[j] = div_ff[QUO_W].neg[j] ? (OUT_W'(0) - mag[j][OUT_W-1:0])
                                           : mag[j][OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NST-1]) begin
         if (div_ff[QUO_W].degen) begin
            rsp_coord_a_ff    <= DEGEN_CODE;
            rsp_coord_b_ff    <= DEGEN_CODE;
            rsp_coord_c_ff    <= DEGEN_CODE;
            rsp_degenerate_ff <= 1'b1;
            rsp_saturated_ff  <= 1'b0;
         end else begin
            rsp_coord_a_ff    <= out_val[0];
            rsp_coord_b_ff    <= out_val[1];
            rsp_coord_c_ff    <= out_val[2];
            rsp_degenerate_ff <= 1'b0;
            rsp_saturated_ff  <= |out_sat;
         end
      end
   end

   assign rsp_coord_a    = $signed(rsp_coord_a_ff);
   assign rsp_coord_b    = $signed(rsp_coord_b_ff);
   assign rsp_coord_c    = $signed(rsp_coord_c_ff);
   assign rsp_degenerate = rsp_degenerate_ff;
   assign rsp_saturated  = rsp_saturated_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `TBC_ASSERT_NOW(a_degen_code, rsp_valid && rsp_degenerate,
      (rsp_coord_a_ff == DEGEN_CODE) && (rsp_coord_b_ff == DEGEN_CODE)
         && (rsp_coord_c_ff == DEGEN_CODE) && !rsp_saturated,
      "degenerate result without fixed coordinates")
   `TBC_ASSERT_NOW(a_stall_only_full, req_stall,
      rsp_valid && rsp_stall && (vld_ff == {NST{1'b1}}),
      "input stalled while pipeline has room")
   `TBC_ASSERT_NEXT(a_thr_write, thr_wr,
      thr_ff == $past(csr_pwdata[THR_W-1:0]),
      "threshold write lost")

endmodule

@@ sim/tetra_barycentric_coords_core_tb.sv @@
// ---------------------------------------------------------------------------
// tetra_barycentric_coords_core_tb
// self-checking bench for the tetrahedron local coordinate core
// ---------------------------------------------------------------------------
// A table of hand-picked tetrahedra runs first: unit and minimal cells,
// flipped orientation, flat and collapsed cells, coordinate extremes. Then
// random queries follow, mostly well-formed cells at random scales, with some
// raw noise and some flattened cells. Typed rows carry their expected result;
// other accepted transactions are predicted by an exact wide-integer Cramer
// solver in the bench and queued; each result is checked against the oldest.
// The degenerate threshold is changed between phases while the core is idle.
module tetra_barycentric_coords_core_tb;
   import tbc_pkg::*;

   localparam int CB    = DEF_COORD_BITS;
   localparam int CFB   = DEF_COORD_FRAC_BITS;
   localparam int OFB   = DEF_OUT_FRAC_BITS;
   localparam int ONE   = 1 << CFB;
   localparam int LIMIT = 400000;
   localparam int DRAIN = 60;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd4;
   localparam logic signed [OUT_W-1:0] MINUS_TEN = -(10 <<< OFB);

   typedef struct packed {
      logic signed [OUT_W-1:0] a;
      logic signed [OUT_W-1:0] b;
      logic signed [OUT_W-1:0] c;
      logic                    degenerate;
      logic                    saturated;
   } coords_type;

   typedef struct {
      logic [FIELD_W-1:0] pt, vp, vq, vr, vs;
      bit                 typed;
      coords_type         want;
   } row_type;

   logic clock = 0;
   logic reset;
   logic req_valid, req_stall;
   logic [FIELD_W-1:0] req_point_xyz, req_vertex_p, req_vertex_q, req_vertex_r, req_vertex_s;
   logic rsp_valid, rsp_stall;
   logic signed [OUT_W-1:0] rsp_coord_a, rsp_coord_b, rsp_coord_c;
   logic rsp_degenerate, rsp_saturated;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   // bench copy of the threshold register
   logic [THR_W-1:0] thr_model;
   coords_type coords_due[$];
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_degen = 0;
   int n_sat = 0;
   int cycles = 0;
   bit calm = 0;

   tetra_barycentric_coords_core i_dut (.*);

   always #5 clock = ~clock;

   // exact solve: A^-1 (m - p) by cofactors, rounded half away from zero
   function automatic coords_type solve_coords(input logic [FIELD_W-1:0] pt, vp, vq, vr, vs,
                                               input logic [THR_W-1:0] thr);
      longint m[3];
      longint e[3][3];
      longint cf[3][3];
      logic [FIELD_W-1:0] cols[3];
      logic signed [127:0] det, num;
      logic [127:0] n, d, q, r, lim;
      logic signed [OUT_W-1:0] res[3];
      coords_type o;
      bit neg, sat;
      longint p;
      cols[0] = vq; cols[1] = vr; cols[2] = vs;
      sat = 0;
      for (int i = 0; i < 3; i++) begin
         p = longint'($signed(vp[i*CB +: CB]));
         m[i] = longint'($signed(pt[i*CB +: CB])) - p;
         for (int j = 0; j < 3; j++)
            e[i][j] = longint'($signed(cols[j][i*CB +: CB])) - p;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            cf[i][j] = e[(i+1)%3][(j+1)%3] * e[(i+2)%3][(j+2)%3]
                     - e[(i+1)%3][(j+2)%3] * e[(i+2)%3][(j+1)%3];
      det = 0;
      for (int j = 0; j < 3; j++)
         det += 128'(signed'(e[0][j])) * 128'(signed'(cf[0][j]));
      d = det < 0 ? -det : det;
      // compare |det| * 2^30 against threshold * 2^(3*frac)
      if (det == 0 || (d << THRESH_FRAC_BITS) < (128'(thr) << (3*CFB))) begin
         o.a = MINUS_TEN; o.b = MINUS_TEN; o.c = MINUS_TEN;
         o.degenerate = 1; o.saturated = 0;
         return o;
      end
      for (int j = 0; j < 3; j++) begin
         num = 0;
         for (int i = 0; i < 3; i++)
            num += 128'(signed'(cf[i][j])) * 128'(signed'(m[i]));
         neg = (num < 0) != (det < 0);
         n = (num < 0 ? -num : num) << OFB;
         q = n / d;
         r = n % d;
         if ((r << 1) >= d) q++;
         lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
         if (q > lim) begin
            sat = 1;
            q = lim;
         end
         res[j] = neg ? -q[OUT_W-1:0] : q[OUT_W-1:0];
      end
      o.a = res[0]; o.b = res[1]; o.c = res[2];
      o.degenerate = 0; o.saturated = sat;
      return o;
   endfunction

   function automatic logic [FIELD_W-1:0] xyz(input int x, y, z);
      return {CB'(z), CB'(y), CB'(x)};
   endfunction

   // signed coordinate at a random scale of 2^0 .. 2^20
   function automatic int rand_coord();
      int sc;
      sc = $urandom_range(0, CB-1);
      return int'($urandom_range(0, (1 << (sc+1)) - 1)) - (1 << sc);
   endfunction

   // ---------------- result side: stall bursts and checking ----------------
   int stall_left = 0;
   int quiet_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            quiet_left = $urandom_range(0, 80);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      coords_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_coord_a, rsp_coord_b, rsp_coord_c, rsp_degenerate, rsp_saturated};
         if (coords_due.size() == 0) begin
            errors++;
            $display("%0t: result transaction with nothing expected: %p", $time, got);
         end else begin
            want = coords_due.pop_front();
            n_checked++;
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch #%0d expected %p actual %p",
                        $time, n_checked, want, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, coords_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------- sender side ----------------
   task automatic send(input logic [FIELD_W-1:0] pt, vp, vq, vr, vs,
                       input bit typed, input coords_type want);
      coords_type exp_c;
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_point_xyz <= pt;
      req_vertex_p  <= vp;
      req_vertex_q  <= vq;
      req_vertex_r  <= vr;
      req_vertex_s  <= vs;
      do @(posedge clock); while (req_stall);
      exp_c = typed ? want : solve_coords(pt, vp, vq, vr, vs, thr_model);
      if (exp_c.degenerate) n_degen++;
      if (exp_c.saturated) n_sat++;
      coords_due.push_back(exp_c);
      n_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (coords_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // register access, setup then access phase; write lands at the access edge
   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr && addr == CSR_DET_THRESHOLD) thr_model = data[THR_W-1:0];
      if (!wr && csr_prdata[THR_W-1:0] !== thr_model) begin
         errors++;
         $display("%0t: threshold readback expected %h actual %h",
                  $time, thr_model, csr_prdata[THR_W-1:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_threshold(input logic [CSR_DATA_W-1:0] v);
      csr_access(1, CSR_DET_THRESHOLD, v);
      csr_access(0, CSR_DET_THRESHOLD, '0);
   endtask

   // random queries: well-formed cells, flattened cells and raw noise
   task automatic random_queries(input int count);
      int kind, px, py, pz;
      logic [FIELD_W-1:0] pt, vp, vq, vr, vs;
      for (int k = 0; k < count; k++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            pt = FIELD_W'({$urandom, $urandom}); vp = FIELD_W'({$urandom, $urandom});
            vq = FIELD_W'({$urandom, $urandom}); vr = FIELD_W'({$urandom, $urandom});
            vs = FIELD_W'({$urandom, $urandom});
         end else begin
            px = rand_coord(); py = rand_coord(); pz = rand_coord();
            vp = xyz(px, py, pz);
            vq = xyz(px + rand_coord(), py + rand_coord(), pz + rand_coord());
            vr = xyz(px + rand_coord(), py + rand_coord(), pz + rand_coord());
            vs = xyz(px + rand_coord(), py + rand_coord(), pz + rand_coord());
            pt = xyz(px + rand_coord(), py + rand_coord(), pz + rand_coord());
            // flat cell: s on the plane through p, q, r
            if (kind == 1) vs = vq + vr - vp;
         end
         send(pt, vp, vq, vr, vs, 0, '0);
      end
   endtask

   row_type rows[$];

   initial begin
      coords_type neg_ten, unit_a, zero;
      logic [FIELD_W-1:0] ones;
      neg_ten = '{MINUS_TEN, MINUS_TEN, MINUS_TEN, 1'b1, 1'b0};
      zero    = '0;
      unit_a  = '{32'sd65536, 32'sd0, 32'sd0, 1'b0, 1'b0};
      ones    = '1;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_point_xyz <= '0; req_vertex_p <= '0; req_vertex_q <= '0;
      req_vertex_r  <= '0; req_vertex_s <= '0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= '0;
      thr_model = THR_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the threshold
      csr_access(0, CSR_DET_THRESHOLD, '0);

      // directed table: point, p, q, r, s, typed, expected
      // collapsed cell at the origin
      rows.push_back('{'0, '0, '0, '0, '0, 1, neg_ten});
      // unit cell, point at p, at (1,1,1), halfway along q, behind p
      rows.push_back('{'0, '0, xyz(ONE,0,0), xyz(0,ONE,0), xyz(0,0,ONE), 1, zero});
      rows.push_back('{xyz(ONE,ONE,ONE), '0, xyz(ONE,0,0), xyz(0,ONE,0), xyz(0,0,ONE), 1,
                       '{32'sd65536, 32'sd65536, 32'sd65536, 1'b0, 1'b0}});
      rows.push_back('{xyz(ONE/2,0,0), '0, xyz(ONE,0,0), xyz(0,ONE,0), xyz(0,0,ONE), 1,
                       '{32'sd32768, 32'sd0, 32'sd0, 1'b0, 1'b0}});
      rows.push_back('{xyz(-ONE,0,0), '0, xyz(ONE,0,0), xyz(0,ONE,0), xyz(0,0,ONE), 1,
                       '{-32'sd65536, 32'sd0, 32'sd0, 1'b0, 1'b0}});
      // smallest cell, determinant exactly at the reset threshold
      rows.push_back('{xyz(1048575,1048575,1048575), '0, xyz(1,0,0), xyz(0,1,0),
                       xyz(0,0,1), 1,
                       '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b1}});
      rows.push_back('{xyz(-1048576,-1048576,-1048576), '0, xyz(1,0,0), xyz(0,1,0),
                       xyz(0,0,1), 1,
                       '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b1}});
      // p at the most negative corner, point on q
      rows.push_back('{xyz(-1048576+ONE,-1048576,-1048576), xyz(-1048576,-1048576,-1048576),
                       xyz(-1048576+ONE,-1048576,-1048576), xyz(-1048576,-1048576+ONE,-1048576),
                       xyz(-1048576,-1048576,-1048576+ONE), 1, unit_a});
      // p at the most positive corner, point on q
      rows.push_back('{xyz(1048575-ONE,1048575,1048575), xyz(1048575,1048575,1048575),
                       xyz(1048575-ONE,1048575,1048575), xyz(1048575,1048575-ONE,1048575),
                       xyz(1048575,1048575,1048575-ONE), 1,
                       '{32'sd65536, 32'sd0, 32'sd0, 1'b0, 1'b0}});
      // flipped orientation: q and r swapped, point on the x axis
      rows.push_back('{xyz(ONE,0,0), '0, xyz(0,ONE,0), xyz(ONE,0,0), xyz(0,0,ONE), 1,
                       '{32'sd0, 32'sd65536, 32'sd0, 1'b0, 1'b0}});
      // all bits set: every vertex the same
      rows.push_back('{ones, ones, ones, ones, ones, 1, neg_ten});
      // flat cell, s = q + r
      rows.push_back('{xyz(7,7,7), '0, xyz(ONE,3,0), xyz(5,ONE,0), xyz(ONE+5,ONE+3,0), 1,
                       neg_ten});
      // irregular cells left to the solver
      rows.push_back('{xyz(300,-200,100), xyz(-5000,4000,17), xyz(9000,-33,1200),
                       xyz(-77,6000,-4000), xyz(1500,2500,-9000), 0, '0});
      rows.push_back('{xyz(-1048576,1048575,0), xyz(3,2,1), xyz(1048575,0,-1048576),
                       xyz(0,-1048576,1048575), xyz(-1048576,1048575,1048575), 0, '0});
      rows.push_back('{63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 63'h1234_5678_9ABC_DEF0,
                       63'h7EDC_BA98_7654_3210, 63'h0F0F_0F0F_F0F0_F0F0, 0, '0});
      foreach (rows[i])
         send(rows[i].pt, rows[i].vp, rows[i].vq, rows[i].vr, rows[i].vs,
              rows[i].typed, rows[i].want);

      random_queries(300);
      // hold off until the pipe is empty, then resume
      wait_idle();
      random_queries(70);

      // zero threshold: only an exactly flat cell is degenerate
      wait_idle();
      set_threshold(64'd0);
      random_queries(370);

      // largest threshold: nearly everything degenerate
      wait_idle();
      set_threshold(64'h7FFF_FFFF_FFFF_FFFF);
      random_queries(200);

      // power-of-two threshold in the middle; a write elsewhere must not land
      wait_idle();
      set_threshold(64'd1 << $urandom_range(20, 50));
      csr_access(1, CSR_UNUSED, {$urandom, $urandom});
      csr_access(0, CSR_DET_THRESHOLD, '0);
      random_queries(370);

      // bit 63 of the write is dropped, leaving the reset value; no idling
      wait_idle();
      set_threshold(64'h8000_0000_0000_0001);
      calm = 1;
      random_queries(540);

      wait_idle();
      $display("sent %0d queries, checked %0d results (%0d degenerate, %0d saturated)",
               n_sent, n_checked, n_degen, n_sat);
      $display("thresholds: reset, zero, maximum, mid-range; stalls on both sides");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d errors", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
